@@ hw/rtl/rrt_pkg.sv @@
// Shared types for the round-robin turn ring: request kinds, status codes
// and the result record passed from the sequencer to the output stage.
// No dependencies.
package rrt_pkg;

    typedef enum logic [1:0] {
        K_ADD  = 2'd0,
        K_ADV  = 2'd1,
        K_SKIP = 2'd2,
        K_REM  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [15:0] acted_id;
        logic [15:0] current_id;
        logic [4:0]  member_count;
        logic        running;
        logic        winner_valid;
        logic [15:0] winner_id;
        logic [15:0] winner_score;
    } t_result;

endpackage

@@ hw/rtl/rrt_ring_mem.sv @@
// Ring storage: member id and score per slot, plus the next-slot links.
// One read address with registered data; ids/scores and links each have a write port.
// Depends on nothing.
module rrt_ring_mem #(
    parameter int MAX_ENTRIES = 16,
    parameter int IW          = 4
) (
    input  logic          i_clk,
    input  logic          i_mw_we,
    input  logic [IW-1:0] i_mw_addr,
    input  logic [15:0]   i_mw_id,
    input  logic [15:0]   i_mw_score,
    input  logic          i_lw_we,
    input  logic [IW-1:0] i_lw_addr,
    input  logic [IW-1:0] i_lw_link,
    input  logic [IW-1:0] i_ra,
    output logic [15:0]   o_rd_id,
    output logic [15:0]   o_rd_score,
    output logic [IW-1:0] o_rd_link
);

    logic [15:0]   r_ids    [MAX_ENTRIES];
    logic [15:0]   r_scores [MAX_ENTRIES];
    logic [IW-1:0] r_links  [MAX_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_mw_we) begin
            r_ids[i_mw_addr]    <= i_mw_id;
            r_scores[i_mw_addr] <= i_mw_score;
        end
        o_rd_id    <= r_ids[i_ra];
        o_rd_score <= r_scores[i_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_lw_we) begin
            r_links[i_lw_addr] <= i_lw_link;
        end
        o_rd_link <= r_links[i_ra];
    end

endmodule

@@ hw/rtl/rrt_seq.sv @@
// Sequencer of the turn ring: walks the linked slots one per cycle through the
// single storage read port, compares ids, and updates head, current and tail.
// Depends on rrt_pkg and rrt_ring_mem.
module rrt_seq
    import rrt_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_player_id,
    input  logic [15:0] i_score,
    output logic        o_res_valid,
    output t_result     o_res,
    input  logic        i_res_take
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SCAN  = 10'b0000000010,
        S_ADD2  = 10'b0000000100,
        S_ADV   = 10'b0000001000,
        S_SKIP1 = 10'b0000010000,
        S_SKIP2 = 10'b0000100000,
        S_REM   = 10'b0001000000,
        S_FIN   = 10'b0010000000,
        S_RDH   = 10'b0100000000,
        S_RDC   = 10'b1000000000
    } t_state;

    t_state                 r_state, n_state;
    logic [IW-1:0]          r_head, n_head;
    logic [IW-1:0]          r_cur, n_cur;
    logic [IW-1:0]          r_tail, n_tail;
    logic [CW-1:0]          r_count, n_count;
    logic [MAX_ENTRIES-1:0] r_used, n_used;

    t_kind         r_kind, n_kind;
    logic [15:0]   r_pid, n_pid;
    logic [15:0]   r_psc, n_psc;
    logic [IW-1:0] r_slot, n_slot;
    logic [IW-1:0] r_prev, n_prev;
    logic [CW-1:0] r_n, n_n;
    t_status       r_status, n_status;
    logic [15:0]   r_acted, n_acted;
    logic [15:0]   r_wid, n_wid;
    logic [15:0]   r_wsc, n_wsc;

    logic          mw_we;
    logic          lw_we;
    logic [IW-1:0] lw_addr;
    logic [IW-1:0] lw_link;
    logic [IW-1:0] ra;
    logic [15:0]   rd_id;
    logic [15:0]   rd_score;
    logic [IW-1:0] rd_link;

    rrt_ring_mem #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .IW         (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_mw_we   (mw_we),
        .i_mw_addr (r_slot),
        .i_mw_id   (r_pid),
        .i_mw_score(r_psc),
        .i_lw_we   (lw_we),
        .i_lw_addr (lw_addr),
        .i_lw_link (lw_link),
        .i_ra      (ra),
        .o_rd_id   (rd_id),
        .o_rd_score(rd_score),
        .o_rd_link (rd_link)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RDC);

    always_comb begin
        o_res.status       = r_status;
        o_res.acted_id     = r_acted;
        o_res.current_id   = (r_count != '0) ? rd_id : 16'd0;
        o_res.member_count = 5'(r_count);
        o_res.running      = (r_count >= CW'(2));
        o_res.winner_valid = (r_count == CW'(1));
        o_res.winner_id    = (r_count == CW'(1)) ? r_wid : 16'd0;
        o_res.winner_score = (r_count == CW'(1)) ? r_wsc : 16'd0;
    end

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_cur    = r_cur;
        n_tail   = r_tail;
        n_count  = r_count;
        n_used   = r_used;
        n_kind   = r_kind;
        n_pid    = r_pid;
        n_psc    = r_psc;
        n_slot   = r_slot;
        n_prev   = r_prev;
        n_n      = r_n;
        n_status = r_status;
        n_acted  = r_acted;
        n_wid    = r_wid;
        n_wsc    = r_wsc;
        mw_we    = 1'b0;
        lw_we    = 1'b0;
        lw_addr  = r_slot;
        lw_link  = r_head;
        ra       = r_cur;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind   = t_kind'(i_kind);
                    n_pid    = i_player_id;
                    n_psc    = i_score;
                    n_acted  = 16'd0;
                    n_status = ST_OK;
                    if (i_kind == K_ADD) begin
                        if (r_count == CW'(MAX_ENTRIES)) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            n_slot  = '0;
                            n_state = S_SCAN;
                        end
                    end else if (r_count == '0) begin
                        n_status = ST_EMPTY;
                        n_state  = S_FIN;
                    end else begin
                        unique case (t_kind'(i_kind))
                            K_ADV: begin
                                ra      = r_cur;
                                n_state = S_ADV;
                            end
                            K_SKIP: begin
                                ra      = r_cur;
                                n_state = S_SKIP1;
                            end
                            K_REM: begin
                                ra      = r_head;
                                n_slot  = r_head;
                                n_prev  = r_tail;
                                n_n     = '0;
                                n_state = S_REM;
                            end
                            default: n_state = S_FIN;
                        endcase
                    end
                end
            end
            S_SCAN: begin
                // One slot of the free map per cycle; a free one exists since the ring is not full.
                if (!r_used[r_slot]) begin
                    mw_we          = 1'b1;
                    n_used[r_slot] = 1'b1;
                    n_count        = r_count + 1'b1;
                    n_acted        = r_pid;
                    lw_we          = 1'b1;
                    if (r_count == '0) begin
                        lw_addr = r_slot;
                        lw_link = r_slot;
                        n_head  = r_slot;
                        n_cur   = r_slot;
                        n_tail  = r_slot;
                        n_state = S_FIN;
                    end else begin
                        lw_addr = r_tail;
                        lw_link = r_slot;
                        n_state = S_ADD2;
                    end
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_ADD2: begin
                // The new tail closes the ring back to the head.
                lw_we   = 1'b1;
                lw_addr = r_slot;
                lw_link = r_head;
                n_tail  = r_slot;
                n_state = S_FIN;
            end
            S_ADV: begin
                n_acted = rd_id;
                n_cur   = rd_link;
                n_state = S_FIN;
            end
            S_SKIP1: begin
                ra      = rd_link;
                n_state = S_SKIP2;
            end
            S_SKIP2: begin
                n_acted = rd_id;
                n_cur   = rd_link;
                n_state = S_FIN;
            end
            S_REM: begin
                if (rd_id == r_pid) begin
                    n_acted        = r_pid;
                    n_used[r_slot] = 1'b0;
                    n_count        = r_count - 1'b1;
                    n_state        = S_FIN;
                    if (r_count == CW'(1)) begin
                        n_head = '0;
                        n_cur  = '0;
                        n_tail = '0;
                    end else begin
                        lw_we   = 1'b1;
                        lw_addr = r_prev;
                        lw_link = rd_link;
                        if (r_cur == r_slot) begin
                            n_cur = rd_link;
                        end
                        if (r_head == r_slot) begin
                            n_head = rd_link;
                        end
                        if (r_tail == r_slot) begin
                            n_tail = r_prev;
                        end
                    end
                end else if ((r_n + 1'b1) == r_count) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_FIN;
                end else begin
                    n_n    = r_n + 1'b1;
                    n_prev = r_slot;
                    n_slot = rd_link;
                    ra     = rd_link;
                end
            end
            S_FIN: begin
                ra      = r_head;
                n_state = S_RDH;
            end
            S_RDH: begin
                n_wid   = rd_id;
                n_wsc   = rd_score;
                ra      = r_cur;
                n_state = S_RDC;
            end
            S_RDC: begin
                // The read address is held so the current id stays on the read data while stalled.
                ra = r_cur;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_cur   <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_cur   <= n_cur;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_pid    <= n_pid;
        r_psc    <= n_psc;
        r_slot   <= n_slot;
        r_prev   <= n_prev;
        r_n      <= n_n;
        r_status <= n_status;
        r_acted  <= n_acted;
        r_wid    <= n_wid;
        r_wsc    <= n_wsc;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("member count above ring size");

    a_used_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == int'(r_count))
        else $error("used slots disagree with member count");

    a_head_cur_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_used[r_head] && r_used[r_cur] && r_used[r_tail]))
        else $error("head, current or tail points at a free slot");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("sequencer idle right after taking a request");

endmodule

@@ hw/rtl/round_robin_ring_turn_order.sv @@
// Top level of the round-robin turn ring: request handshake, sequencer and the
// result register that decouples the result channel. Depends on rrt_pkg and rrt_seq.
//
//   channel  | handshake          | payload
//   request  | i_valid / o_ready  | i_kind, i_player_id, i_score
//   result   | o_valid / i_ready  | o_status, o_acted_id, o_current_id, o_member_count,
//            |                    | o_running, o_winner_valid, o_winner_id, o_winner_score
//
// One request at a time; o_ready is high only while the sequencer is idle. Once a
// request is taken, advance reads the current slot, skip reads two slots, add scans
// the free map from slot 0 and then links the new slot in, remove walks the ring from
// the head one slot per cycle until a match or the member count is reached, and a
// refused add or an empty ring needs none; then the head is read for the winner
// and the current slot for the result. Reset empties the ring; no clearing pass is
// needed. A stalled result holds the sequencer in its last state, and the next
// request is taken once the result is loaded.
module round_robin_ring_turn_order
    import rrt_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_player_id,
    input  logic [15:0] i_score,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_acted_id,
    output logic [15:0] o_current_id,
    output logic [4:0]  o_member_count,
    output logic        o_running,
    output logic        o_winner_valid,
    output logic [15:0] o_winner_id,
    output logic [15:0] o_winner_score
);

    logic    res_valid;
    t_result res;
    logic    res_take;
    logic    r_out_valid;
    t_result r_res;

    assign res_take = !r_out_valid || i_ready;

    rrt_seq #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_kind     (i_kind),
        .i_player_id(i_player_id),
        .i_score    (i_score),
        .o_res_valid(res_valid),
        .o_res      (res),
        .i_res_take (res_take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_res <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_res.status;
    assign o_acted_id     = r_res.acted_id;
    assign o_current_id   = r_res.current_id;
    assign o_member_count = r_res.member_count;
    assign o_running      = r_res.running;
    assign o_winner_valid = r_res.winner_valid;
    assign o_winner_id    = r_res.winner_id;
    assign o_winner_score = r_res.winner_score;

endmodule

@@ tb/round_robin_ring_turn_order_tb.sv @@
// Self-checking testbench for the round-robin turn ring: a directed table followed by
// weighted random requests, checked against a ring predictor or a typed row's result.
// Depends on rrt_pkg and round_robin_ring_turn_order.
`timescale 1ns / 1ps

module round_robin_ring_turn_order_tb;
    import rrt_pkg::*;

    localparam int RING_SLOTS     = 16;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int HOLD_AT        = 4000;
    localparam int HOLD_LEN       = 600;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int REPORT_CAP     = 40;

    localparam t_result NO_MEMBERS = '{ST_EMPTY, 16'h0, 16'h0, 5'd0, 1'b0, 1'b0, 16'h0, 16'h0};

    typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} t_rx_mode;
    typedef enum {MIX_FILL, MIX_EVEN, MIX_DRAIN, MIX_ANY} t_mix;

    typedef struct {
        t_kind       kind;
        logic [15:0] pid;
        logic [15:0] score;
        bit          typed;
        t_result     want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind = K_ADD;
    logic [15:0] i_player_id = 16'h0;
    logic [15:0] i_score = 16'h0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_acted_id;
    logic [15:0] o_current_id;
    logic [4:0]  o_member_count;
    logic        o_running;
    logic        o_winner_valid;
    logic [15:0] o_winner_id;
    logic [15:0] o_winner_score;

    round_robin_ring_turn_order #(.MAX_ENTRIES(RING_SLOTS)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_player_id    (i_player_id),
        .i_score        (i_score),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_acted_id     (o_acted_id),
        .o_current_id   (o_current_id),
        .o_member_count (o_member_count),
        .o_running      (o_running),
        .o_winner_valid (o_winner_valid),
        .o_winner_id    (o_winner_id),
        .o_winner_score (o_winner_score)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Ring predictor state.
    logic [15:0] slot_id    [RING_SLOTS];
    logic [15:0] slot_score [RING_SLOTS];
    int          slot_next  [RING_SLOTS];
    bit          slot_busy  [RING_SLOTS];
    int          head_at = 0;
    int          turn_at = 0;
    int          members = 0;

    t_result answers_due [$];
    t_row    plan [$];
    int      mismatches = 0;
    int      idle_cycles = 0;
    t_result due;

    initial begin
        for (int s = 0; s < RING_SLOTS; s++) begin
            slot_id[s] = 16'h0;
            slot_score[s] = 16'h0;
            slot_next[s] = 0;
            slot_busy[s] = 1'b0;
        end
    end

    // The tail is the slot whose link points back at the head.
    function automatic int last_slot();
        int t, n;
        t = head_at;
        for (n = 0; n < RING_SLOTS && slot_next[t] != head_at; n++)
            t = slot_next[t];
        return t;
    endfunction

    function automatic t_result ring_step(t_kind k, logic [15:0] pid, logic [15:0] sc);
        t_result r;
        int s, prev, t, n;
        bit hit;
        r = '0;
        r.status = ST_OK;
        case (k)
            K_ADD: begin
                s = 0;
                while (s < RING_SLOTS && slot_busy[s]) s++;
                if (members >= RING_SLOTS || s >= RING_SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    slot_id[s] = pid;
                    slot_score[s] = sc;
                    slot_busy[s] = 1'b1;
                    if (members == 0) begin
                        head_at = s;
                        turn_at = s;
                        slot_next[s] = s;
                    end else begin
                        slot_next[last_slot()] = s;
                        slot_next[s] = head_at;
                    end
                    members++;
                    r.acted_id = pid;
                end
            end
            K_ADV: begin
                if (members == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.acted_id = slot_id[turn_at];
                    turn_at = slot_next[turn_at];
                end
            end
            K_SKIP: begin
                if (members == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    s = slot_next[turn_at];
                    r.acted_id = slot_id[s];
                    turn_at = slot_next[s];
                end
            end
            K_REM: begin
                if (members == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // Search from the head so the first of several equal ids goes.
                    prev = last_slot();
                    t = head_at;
                    hit = 1'b0;
                    for (n = 0; n < members && !hit; n++) begin
                        if (slot_id[t] == pid) begin
                            hit = 1'b1;
                        end else begin
                            prev = t;
                            t = slot_next[t];
                        end
                    end
                    if (!hit) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        r.acted_id = pid;
                        slot_busy[t] = 1'b0;
                        if (members == 1) begin
                            head_at = 0;
                            turn_at = 0;
                        end else begin
                            s = slot_next[t];
                            slot_next[prev] = s;
                            if (turn_at == t) turn_at = s;
                            if (head_at == t) head_at = s;
                        end
                        members--;
                    end
                end
            end
        endcase
        r.current_id   = (members != 0) ? slot_id[turn_at] : 16'h0;
        r.member_count = members[4:0];
        r.running      = (members >= 2);
        r.winner_valid = (members == 1);
        r.winner_id    = (members == 1) ? slot_id[head_at] : 16'h0;
        r.winner_score = (members == 1) ? slot_score[head_at] : 16'h0;
        return r;
    endfunction

    // Small ids collide often, which exercises duplicate handling.
    function automatic logic [15:0] any_id();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 16'($urandom_range(0, 7));
        if (roll < 50) return 16'h0000;
        if (roll < 55) return 16'hFFFF;
        if (roll < 60) return 16'h8000;
        if (roll < 65) return 16'h7FFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic t_row plain(t_kind k, logic [15:0] pid, logic [15:0] sc);
        return '{k, pid, sc, 1'b0, '0};
    endfunction

    function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t ns: result with no request pending, expected none, actual id %h",
                             $time, o_acted_id);
            end else begin
                due = answers_due.pop_front();
                check_field("status", due.status, o_status);
                check_field("acted_id", due.acted_id, o_acted_id);
                check_field("current_id", due.current_id, o_current_id);
                check_field("member_count", due.member_count, o_member_count);
                check_field("running", due.running, o_running);
                check_field("winner_valid", due.winner_valid, o_winner_valid);
                check_field("winner_id", due.winner_id, o_winner_id);
                check_field("winner_score", due.winner_score, o_winner_score);
            end
        end
    end

    // Result side back-pressure, including one long hold-off so the block backs up.
    initial begin : result_sink
        int unsigned cyc;
        t_rx_mode mode;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc = cyc + 1;
            if (cyc == HOLD_AT) begin
                i_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                cyc = cyc + HOLD_LEN;
            end else begin
                mode = t_rx_mode'((cyc / 250) % 4);
                case (mode)
                    RX_OPEN:     i_ready <= 1'b1;
                    RX_RANDOM:   i_ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: i_ready <= ((cyc % 7) > 2);
                    RX_SPARSE:   i_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[round_robin_ring_turn_order] ERROR");
            $finish;
        end
    end

    initial begin : request_source
        logic [15:0] dir_ids [16];
        t_row row;
        t_mix mix;
        t_result model;
        int burst_left, total, roll, pick, s;

        dir_ids = '{16'h0000, 16'h0001, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'h00FF,
                    16'hFF00, 16'h0000, 16'h0003, 16'h1234, 16'hFEDC, 16'h0F0F, 16'hF0F0,
                    16'h0001, 16'hFFFE};

        // Operations on an empty ring.
        plan.push_back('{K_ADV,  16'h0000, 16'h0000, 1'b1, NO_MEMBERS});
        plan.push_back('{K_SKIP, 16'hFFFF, 16'hFFFF, 1'b1, NO_MEMBERS});
        plan.push_back('{K_REM,  16'h0005, 16'h0000, 1'b1, NO_MEMBERS});
        // A single member: skip lands back on itself, then removal empties the ring.
        plan.push_back('{K_ADD, 16'hFFFF, 16'hFFFF, 1'b1,
                         '{ST_OK, 16'hFFFF, 16'hFFFF, 5'd1, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF}});
        plan.push_back(plain(K_SKIP, 16'h0000, 16'h0000));
        plan.push_back('{K_REM, 16'hFFFF, 16'h0000, 1'b1,
                         '{ST_OK, 16'hFFFF, 16'h0, 5'd0, 1'b0, 1'b0, 16'h0, 16'h0}});
        foreach (dir_ids[i])
            plan.push_back(plain(K_ADD, dir_ids[i], dir_ids[i] ^ 16'h5A5A));
        plan.push_back('{K_ADD, 16'h4321, 16'h1111, 1'b1,
                         '{ST_FULL, 16'h0, 16'h0000, 5'd16, 1'b1, 1'b0, 16'h0, 16'h0}});
        plan.push_back('{K_REM, 16'hFFFF, 16'h0000, 1'b1,
                         '{ST_NOTFOUND, 16'h0, 16'h0000, 5'd16, 1'b1, 1'b0, 16'h0, 16'h0}});
        // Advance, then remove the current member, then the head (first of two zeros).
        plan.push_back(plain(K_ADV, 16'h0000, 16'h0000));
        plan.push_back(plain(K_REM, 16'h0001, 16'h0000));
        plan.push_back(plain(K_REM, 16'h0000, 16'h0000));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        burst_left = 0;
        total = plan.size() + RANDOM_ITEMS;
        for (int n = 0; n < total; n++) begin
            if (n < plan.size()) begin
                row = plan[n];
            end else begin
                mix = t_mix'(((n - plan.size()) / 60) % 4);
                roll = $urandom_range(0, 99);
                row.typed = 1'b0;
                row.want = '0;
                row.pid = any_id();
                row.score = 16'($urandom_range(0, 65535));
                case (mix)
                    MIX_FILL:  row.kind = roll < 70 ? K_ADD : roll < 80 ? K_ADV :
                                          roll < 90 ? K_SKIP : K_REM;
                    MIX_EVEN:  row.kind = roll < 35 ? K_ADD : roll < 55 ? K_ADV :
                                          roll < 70 ? K_SKIP : K_REM;
                    MIX_DRAIN: row.kind = roll < 15 ? K_ADD : roll < 25 ? K_ADV :
                                          roll < 35 ? K_SKIP : K_REM;
                    default:   row.kind = t_kind'($urandom_range(0, 3));
                endcase
                // Most removals name a member that is actually in the ring.
                if (row.kind == K_REM && members > 0 && $urandom_range(0, 3) != 0) begin
                    pick = $urandom_range(0, members - 1);
                    for (s = 0; s < RING_SLOTS; s++) begin
                        if (slot_busy[s]) begin
                            if (pick == 0) row.pid = slot_id[s];
                            pick--;
                        end
                    end
                end
            end

            if (burst_left == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 24);
            end
            burst_left--;

            i_valid     <= 1'b1;
            i_kind      <= row.kind;
            i_player_id <= row.pid;
            i_score     <= row.score;
            do @(posedge i_clk); while (!o_ready);
            model = ring_step(row.kind, row.pid, row.score);
            answers_due.push_back(row.typed ? row.want : model);
        end
        i_valid <= 1'b0;

        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("[round_robin_ring_turn_order] OK");
        else
            $display("[round_robin_ring_turn_order] ERROR");
        $finish;
    end

endmodule
